// ===== hdl/signed_int_to_decimal_ascii_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ITOA_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ITOA_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== hdl/itoa_pkg.sv =====
package itoa_pkg;

    localparam int DIGIT_W = 4;

    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_NINE  = 6'd57;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // Double-dabble correction: digits of 5 or more get 3 added before the shift
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

    typedef struct packed {
        logic load;        // capture a new request
        logic conv_step;   // one shift-and-add-3 step
        logic skip;        // drop one leading zero digit
        logic emit_sign;   // send the minus sign
        logic emit_digit;  // send the top digit and drop it
    } cmd_t;

    typedef struct packed {
        logic conv_last;   // current step is the final conversion step
        logic top_zero;    // top BCD digit is zero
        logic one_left;    // one digit remains
        logic neg;         // value of the request is negative
    } status_t;

endpackage

// ===== hdl/itoa_dp.sv =====
module itoa_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itoa_pkg::cmd_t                cmd,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output itoa_pkg::status_t             status,
    output logic [5:0]                    ascii_char,
    output logic                          is_last,
    output logic                          strobe
);

    // Digits needed for a magnitude of up to 2**(VALUE_WIDTH-1)
    localparam int NDIG  = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_W = NDIG * itoa_pkg::DIGIT_W;
    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [VALUE_WIDTH-1:0]       mag_reg, mag_next;
    logic [BCD_W-1:0]             bcd_reg, bcd_next;
    logic [BIT_W-1:0]             bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]             dig_cnt_reg, dig_cnt_next;
    logic                         neg_reg, neg_next;
    logic [5:0]                   ascii_char_reg, ascii_char_next;
    logic                         is_last_reg, is_last_next;
    logic                         strobe_reg, strobe_next;
    logic [BCD_W-1:0]             bcd_adj;
    logic [VALUE_WIDTH-1:0]       value_u;
    logic [itoa_pkg::DIGIT_W-1:0] top_digit;

    assign value_u   = value;
    assign top_digit = bcd_reg[BCD_W-1 -: itoa_pkg::DIGIT_W];

    // add-3 correction, per digit
    always_comb
    begin
        logic [itoa_pkg::DIGIT_W-1:0] d;
        d       = '0;
        bcd_adj = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W];
            if (d >= itoa_pkg::BCD_ADJ_MIN)
            begin
                d = d + itoa_pkg::BCD_ADJ;
            end
            bcd_adj[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] = d;
        end
    end

    always_comb
    begin
        mag_next        = mag_reg;
        bcd_next        = bcd_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        neg_next        = neg_reg;
        ascii_char_next = ascii_char_reg;
        is_last_next    = is_last_reg;
        strobe_next     = 1'b0;

        if (cmd.load)
        begin
            neg_next     = value_u[VALUE_WIDTH-1];
            mag_next     = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
            bcd_next     = '0;
            bit_cnt_next = '0;
            dig_cnt_next = CNT_W'(NDIG);
        end
        else if (cmd.conv_step)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        else if (cmd.skip)
        begin
            bcd_next     = {bcd_reg[BCD_W-itoa_pkg::DIGIT_W-1:0], {itoa_pkg::DIGIT_W{1'b0}}};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
        else if (cmd.emit_sign)
        begin
            ascii_char_next = itoa_pkg::CHAR_MINUS;
            is_last_next    = 1'b0;
            strobe_next     = 1'b1;
        end
        else if (cmd.emit_digit)
        begin
            ascii_char_next = itoa_pkg::CHAR_ZERO + {2'b00, top_digit};
            is_last_next    = status.one_left;
            strobe_next     = 1'b1;
            bcd_next        = {bcd_reg[BCD_W-itoa_pkg::DIGIT_W-1:0], {itoa_pkg::DIGIT_W{1'b0}}};
            dig_cnt_next    = dig_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        bcd_reg        <= bcd_next;
        bit_cnt_reg    <= bit_cnt_next;
        dig_cnt_reg    <= dig_cnt_next;
        neg_reg        <= neg_next;
        ascii_char_reg <= ascii_char_next;
        is_last_reg    <= is_last_next;
    end

    assign status.conv_last = (bit_cnt_reg == BIT_W'(VALUE_WIDTH - 1));
    assign status.top_zero  = (top_digit == '0);
    assign status.one_left  = (dig_cnt_reg == CNT_W'(1));
    assign status.neg       = neg_reg;

    assign ascii_char = ascii_char_reg;
    assign is_last    = is_last_reg;
    assign strobe     = strobe_reg;

endmodule

// ===== hdl/itoa_ctrl.sv =====
module itoa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  itoa_pkg::status_t status,
    output itoa_pkg::cmd_t    cmd,
    output logic              busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // strip leading zeros, always keep at least one digit
                if (status.top_zero && !status.one_left)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.neg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                if (status.one_left)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// The first character comes after the bit-serial shift-and-add-3 loop and the
// leading-zero strip over D = W*3/10 + 1 digit slots, where W = VALUE_WIDTH;
// the rest follow one per cycle with no gaps.
// Reset (rst_n, async, active low) idles the controller and clears the strobe.
// Results cannot be stalled: each character is marked by strobe for exactly one cycle.
//
// Signed integer to decimal ASCII converter.
//
// Request: 'value' is taken on a clock edge with start high and busy low.
// The datapath forms the unsigned magnitude (so the most negative value prints
// in full) and runs a double-dabble conversion, one magnitude bit per cycle,
// into D BCD digits. Leading zero digits are then shifted out one per cycle,
// keeping at least one digit so that zero prints as '0'.
//
// Output: a minus sign first for negative values, then the digits most
// significant first. Each character is shown on ascii_char with strobe high for
// one cycle; is_last marks the final character of the number.
//
// busy falls on the same edge that launches the last character, so a new
// request can be taken while that character is still on the ports.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic [5:0]                    ascii_char,
    output logic                          is_last,
    output logic                          strobe
);

    itoa_pkg::cmd_t    cmd;
    itoa_pkg::status_t status;

    // Sequencer: load, convert, strip zeros, sign, emit digits
    itoa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Magnitude shifter, BCD register, counters and output register
    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .status     (status),
        .ascii_char (ascii_char),
        .is_last    (is_last),
        .strobe     (strobe)
    );

endmodule

// ===== hdl/itoa_checker.sv =====
`include "signed_int_to_decimal_ascii_assert.svh"

module itoa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [5:0] ascii_char,
    input logic       is_last,
    input logic       strobe
);

    logic is_minus;
    logic is_digit;

    assign is_minus = (ascii_char == itoa_pkg::CHAR_MINUS);
    assign is_digit = (ascii_char >= itoa_pkg::CHAR_ZERO) && (ascii_char <= itoa_pkg::CHAR_NINE);

    `ITOA_ASSERT_NOW(a_char_legal, strobe, is_minus || is_digit, "illegal character")
    `ITOA_ASSERT_NOW(a_minus_not_last, strobe && is_minus, !is_last, "minus marked last")
    `ITOA_ASSERT_NEXT(a_minus_digit, strobe && is_minus, strobe && is_digit, "no digit after -")
    `ITOA_ASSERT_NOW(a_last_frees, strobe && is_last, !busy, "busy after last char")
    `ITOA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe, "request not started")

endmodule

bind signed_int_to_decimal_ascii itoa_checker u_itoa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .ascii_char (ascii_char),
    .is_last    (is_last),
    .strobe     (strobe)
);
